/* rtl/hpt_pkg.sv */
// ============================================================================
// hpt_pkg: shared types and constants for the homogeneous point transform
// Register reset values, field widths and the divider stage payload.
// ============================================================================
`default_nettype none

package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int QUO_W         = 31;
  localparam int DIV_STAGES    = QUO_W;

  localparam logic [63:0] REG_RESET [NUM_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  // Payload carried down the divider stages.
  typedef struct packed {
    logic                   cmd;
    logic                   wz;
    logic [2:0]             sat;
    logic [2:0]             neg;
    logic [2:0][63:0]       rem;
    logic [63:0]            wm;
    logic [2:0][QUO_W-1:0]  quo;
    logic [2:0][31:0]       rot;
  } div_t;

endpackage

`default_nettype wire

/* rtl/homogeneous_point_transform_core.sv */
// ============================================================================
// homogeneous_point_transform_core: 4x4 vertex transform with divide
// Q-format row-vector transform, perspective divide and saturation.
// ============================================================================
// The core takes one point per clock while the output is not stalled and
// returns one result per point, in order, through one input register, one
// multiply stage with twelve 32x32 products, one sum stage, one sign and
// magnitude stage, 31 restoring divide stages (one quotient bit each, three
// lanes side by side) and the output register. A stall on the result side
// holds the whole pipeline; the input is ready whenever the output register
// is empty or being taken. cmd travels in in_tuser; w_zero in out_tuser.
// Configuration writes go to the matrix registers and must only be issued
// while the pipeline is empty.
`default_nettype none

module homogeneous_point_transform_core #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [95:0]                     in_tdata,   // point_x, point_y, point_z
  input  wire logic                            in_tuser,   // cmd
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [95:0]                          out_tdata,  // out_x, out_y, out_z
  output logic                                 out_tuser,  // w_zero
  input  wire logic                            cfg_we,
  input  wire logic [hpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [63:0]                     cfg_wdata
);

  localparam int NS = hpt_pkg::DIV_STAGES;

  logic [63:0] regs_r [hpt_pkg::NUM_REGS];
  logic        en;

  // Matrix registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) regs_r[i] <= hpt_pkg::REG_RESET[i];
    end else if (cfg_we && (cfg_index < 4'(hpt_pkg::NUM_REGS))) begin
      regs_r[cfg_index[2:0]] <= cfg_wdata;
    end
  end

  // Element m[r][c] as a signed value.
  logic signed [31:0] m [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = (c % 2 == 1) ? regs_r[r*2 + c/2][63:32] : regs_r[r*2 + c/2][31:0];
      end
    end
  end

  // The whole pipeline advances unless a finished result is held.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: input register.
  logic               v1_r, cmd1_r;
  logic signed [31:0] p1_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r  <= in_tuser;
      p1_r[0] <= in_tdata[31:0];
      p1_r[1] <= in_tdata[63:32];
      p1_r[2] <= in_tdata[95:64];
    end
  end

  // Stage 2: twelve exact products.
  logic               v2_r, cmd2_r;
  logic signed [63:0] prod_r [3][4];
  logic signed [31:0] trans_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cmd2_r <= cmd1_r;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) prod_r[r][c] <= p1_r[r] * m[r][c];
      end
      for (int c = 0; c < 4; c++) trans_r[c] <= m[3][c];
    end
  end

  // Stage 3: floor-shifted products summed, translation added in full mode.
  logic               v3_r, cmd3_r;
  logic signed [63:0] sum_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cmd3_r <= cmd2_r;
      for (int c = 0; c < 4; c++) begin
        sum_r[c] <= (prod_r[0][c] >>> FRAC_BITS) + (prod_r[1][c] >>> FRAC_BITS)
                  + (prod_r[2][c] >>> FRAC_BITS)
                  + (cmd2_r ? 64'sd0 : 64'(trans_r[c]));
      end
    end
  end

  // Stage 4: magnitudes, dividend, saturation test and rotate-only results.
  hpt_pkg::div_t dv_nxt;
  logic [63:0]   wmag;
  logic [63:0]   nmag;
  logic [63:0]   dvd;
  always_comb begin
    dv_nxt     = '0;
    dv_nxt.cmd = cmd3_r;
    wmag       = sum_r[3][63] ? 64'(-sum_r[3]) : 64'(sum_r[3]);
    dv_nxt.wm  = wmag;
    dv_nxt.wz  = (sum_r[3] == 64'sd0);
    nmag       = '0;
    dvd        = '0;
    for (int c = 0; c < 3; c++) begin
      nmag          = sum_r[c][63] ? 64'(-sum_r[c]) : 64'(sum_r[c]);
      dvd           = nmag << FRAC_BITS;
      dv_nxt.rem[c] = dvd;
      dv_nxt.neg[c] = sum_r[c][63] ^ sum_r[3][63];
      dv_nxt.sat[c] = {31'd0, dvd} >= {wmag, 31'd0};
      if (sum_r[c] > 64'sd2147483647)       dv_nxt.rot[c] = 32'h7FFF_FFFF;
      else if (sum_r[c] < -64'sd2147483648) dv_nxt.rot[c] = 32'h8000_0000;
      else                                  dv_nxt.rot[c] = sum_r[c][31:0];
    end
  end

  // Divide stages: stage s decides quotient bit NS-s.
  hpt_pkg::div_t dv_r  [NS+1];
  logic          dvv_r [NS+1];
  always_ff @(posedge clk) begin
    if (!rst_n) dvv_r[0] <= 1'b0;
    else if (en) dvv_r[0] <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (en) dv_r[0] <= dv_nxt;
  end

  for (genvar s = 1; s <= NS; s++) begin : g_div
    localparam int K = NS - s;
    hpt_pkg::div_t st_nxt;
    logic [94:0]   dsh;
    always_comb begin
      st_nxt = dv_r[s-1];
      dsh    = {31'd0, dv_r[s-1].wm} << K;
      for (int c = 0; c < 3; c++) begin
        if ({31'd0, dv_r[s-1].rem[c]} >= dsh) begin
          st_nxt.rem[c]    = dv_r[s-1].rem[c] - dsh[63:0];
          st_nxt.quo[c][K] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dvv_r[s] <= 1'b0;
      else if (en) dvv_r[s] <= dvv_r[s-1];
    end
    always_ff @(posedge clk) begin
      if (en) dv_r[s] <= st_nxt;
    end
  end

  // Output register.
  logic [95:0] res_nxt;
  logic [31:0] qs;
  always_comb begin
    res_nxt = '0;
    qs      = '0;
    for (int c = 0; c < 3; c++) begin
      qs = {1'b0, dv_r[NS].quo[c]};
      if (dv_r[NS].cmd)            res_nxt[c*32 +: 32] = dv_r[NS].rot[c];
      else if (dv_r[NS].wz)        res_nxt[c*32 +: 32] = '0;
      else if (dv_r[NS].sat[c])    res_nxt[c*32 +: 32] = dv_r[NS].neg[c] ? 32'h8000_0000
                                                                        : 32'h7FFF_FFFF;
      else                         res_nxt[c*32 +: 32] = dv_r[NS].neg[c] ? -qs : qs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= dvv_r[NS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= res_nxt;
      out_tuser <= !dv_r[NS].cmd && dv_r[NS].wz;
    end
  end

endmodule

`default_nettype wire

/* rtl/hpt_checker.sv */
// ============================================================================
// hpt_checker: port-level checks for the point transform core
// Watches the stream ports and flags handshake or result slips.
// ============================================================================
`default_nettype none

module hpt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [95:0] out_tdata,
  input wire logic        out_tuser
);

  // A held result beat keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // With no result waiting the core must take input.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input not ready with empty output");

  // A zero-w result carries zero coordinates.
  a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 96'd0)
    else $error("zero-w beat with nonzero data");

endmodule

bind homogeneous_point_transform_core hpt_checker u_hpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

/* test/tb_top.sv */
// ============================================================================
// tb_top: stream test of the homogeneous point transform core
// Drives points with bursty valid and a stalling receiver, predicts every
// transformed point in the scoreboard and compares results in order. The
// matrix is rewritten between phases while the pipeline is empty.
// ============================================================================
`default_nettype none

// Scoreboard: holds the matrix copy and the queue of predicted points.
class point_board;
  logic [63:0] mtx_regs [8];
  logic [96:0] pending_pts [$];
  int errors;

  function new();
    for (int i = 0; i < 8; i++) mtx_regs[i] = hpt_pkg::REG_RESET[i];
    errors = 0;
  endfunction

  function void write_reg(int idx, logic [63:0] val);
    if (idx < 8) mtx_regs[idx] = val;
  endfunction

  function logic signed [63:0] elem(int r, int c);
    logic [63:0] w;
    w = mtx_regs[r * 2 + c / 2];
    return (c % 2) ? {{32{w[63]}}, w[63:32]} : {{32{w[31]}}, w[31:0]};
  endfunction

  // Column sum with each product floored by the fraction width.
  function logic signed [63:0] col_sum(logic signed [63:0] p [3], int c, bit trans);
    logic signed [63:0] s;
    s = 0;
    for (int r = 0; r < 3; r++) s += (p[r] * elem(r, c)) >>> 16;
    if (trans) s += elem(3, c);
    return s;
  endfunction

  function logic [31:0] sat_mag(bit neg, logic [63:0] mag);
    if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function logic [31:0] sat_val(logic signed [63:0] v);
    return sat_mag(v < 0, (v < 0) ? -v : v);
  endfunction

  function logic [31:0] div_q(logic signed [63:0] n, logic signed [63:0] w);
    logic [63:0] nm, wm, q;
    nm = (n < 0) ? -n : n;
    wm = (w < 0) ? -w : w;
    q = (nm << 16) / wm;
    return sat_mag((n < 0) != (w < 0), q);
  endfunction

  // Note an accepted point and queue its transformed result.
  function void note_point(logic cmd, logic [95:0] data);
    logic signed [63:0] p [3];
    logic signed [63:0] w;
    logic [31:0] o [3];
    logic wz;
    for (int i = 0; i < 3; i++) p[i] = {{32{data[32*i+31]}}, data[32*i +: 32]};
    wz = 1'b0;
    if (cmd) begin
      for (int c = 0; c < 3; c++) o[c] = sat_val(col_sum(p, c, 1'b0));
    end else begin
      w = col_sum(p, 3, 1'b1);
      if (w == 0) begin
        wz = 1'b1;
        for (int c = 0; c < 3; c++) o[c] = 32'd0;
      end else begin
        for (int c = 0; c < 3; c++) o[c] = div_q(col_sum(p, c, 1'b1), w);
      end
    end
    pending_pts.push_back({wz, o[2], o[1], o[0]});
  endfunction

  // Compare one accepted result against the oldest prediction.
  function void check_result(logic wz, logic [95:0] data);
    logic [96:0] e;
    if (pending_pts.size() == 0) begin
      $display("%0t: unexpected result %h/%b", $time, data, wz);
      errors++;
      return;
    end
    e = pending_pts.pop_front();
    for (int i = 0; i < 3; i++)
      if (e[32*i +: 32] !== data[32*i +: 32]) begin
        $display("%0t: coord %0d expected %h actual %h", $time, i, e[32*i +: 32],
                 data[32*i +: 32]);
        errors++;
      end
    if (e[96] !== wz) begin
      $display("%0t: w_zero expected %b actual %b", $time, e[96], wz);
      errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  // Receiver stall pattern selector; mode 0 never stalls.
  int stall_mode = 0;
  int idle_count = 0;
  point_board board;

  always #5 clk = ~clk;

  homogeneous_point_transform_core uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  // Sample results at the rising edge; also run the stall watchdog here.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_result(out_tuser, out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        idle_count = 0;
      else if (board.pending_pts.size() != 0 || in_tvalid)
        idle_count++;
      if (idle_count >= WATCHDOG_CYCLES) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Receiver: stall patterns change per phase; drive on the falling edge.
  always @(negedge clk) begin
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(3) != 0);
      2: out_tready <= ($urandom_range(3) == 0);
      default: out_tready <= (($time / 10) % 7) < 4;
    endcase
  end

  // Interesting coordinate values: extremes and small fixed-point numbers.
  function logic [31:0] pick_coord();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(8)) - 4) << 16;
      3: return 32'(signed'($urandom_range(2000)) - 1000) << 8;
      4: return {{16{1'b0}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function logic [31:0] pick_elem();
    case ($urandom_range(6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return 32'(signed'($urandom_range(4)) - 2) << 16;
      4: return 32'(signed'($urandom_range(512)) - 256) << 8;
      default: return $urandom;
    endcase
  endfunction

  // Send one point and hold it until it is taken.
  task automatic send_point(logic cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_point(cmd, {z, y, x});
    @(negedge clk);
  endtask

  task automatic idle_sender(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Wait until every prediction has been matched, then let the pipe settle.
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (board.pending_pts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One write, then cfg_we is dropped before the next so consecutive writes never collide.
  task automatic write_reg(int idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx[hpt_pkg::CFG_IDX_W-1:0];
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, val);
    @(negedge clk);
  endtask

  // A burst of random points with random gaps; most in full mode.
  task automatic random_phase(int count);
    int left;
    left = count;
    while (left > 0) begin
      int burst;
      burst = $urandom_range(12, 1);
      for (int i = 0; i < burst && left > 0; i++, left--)
        send_point($urandom_range(3) == 0, pick_coord(), pick_coord(), pick_coord());
      if ($urandom_range(2) != 0) idle_sender($urandom_range(6, 1));
    end
  endtask

  initial begin
    board = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed points through the identity matrix, then a projective one.
    send_point(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_point(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_point(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000);
    send_point(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    drain_pipe();

    // w = y - 1 (zero at y = 1.0); the points give w of either sign.
    write_reg(3, {32'h0001_0000, 32'h0000_0000});
    write_reg(7, {32'hFFFF_0000, 32'h0000_0000});
    send_point(1'b0, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
    send_point(1'b0, 32'h0002_0000, 32'hFFFD_0000, 32'h0000_8000);
    send_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0001);
    send_point(1'b0, 32'h0002_0000, 32'h0003_0000, 32'h0003_0000);
    send_point(1'b1, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
    drain_pipe();
    // Index beyond the register file must be ignored.
    write_reg(9, 64'hFFFF_FFFF_FFFF_FFFF);
    send_point(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    drain_pipe();

    // Random phases with new matrices, the extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 4;
      for (int r = 0; r < 8; r++) begin
        case (ph)
          0: write_reg(r, 64'hFFFF_FFFF_FFFF_FFFF);
          1: write_reg(r, {32'h7FFF_FFFF, 32'h8000_0000});
          default: write_reg(r, {pick_elem(), pick_elem()});
        endcase
      end
      random_phase(80);
      // Pause until every result has come before the next phase.
      drain_pipe();
    end

    // Back to small-magnitude matrices so many quotients do not saturate.
    stall_mode = 3;
    for (int r = 0; r < 8; r++)
      write_reg(r, {32'(signed'($urandom_range(4)) - 2) << 16,
                    32'(signed'($urandom_range(4)) - 2) << 16});
    random_phase(40);
    drain_pipe();

    if (board.errors == 0 && board.pending_pts.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

`default_nettype wire
